### rtl/tccb_pkg.sv
`timescale 1ns / 1ps

package tccb_pkg;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;

  localparam int unsigned CursorColW = 7;
  localparam int unsigned CursorRowW = 5;
  localparam int unsigned ReadRowW   = 5;
  localparam int unsigned ReadColW   = 7;

  // input tdata layout
  localparam int unsigned InCharLsb = 0;
  localparam int unsigned InFgLsb   = 8;
  localparam int unsigned InBgLsb   = 12;
  localparam int unsigned InRowLsb  = 16;
  localparam int unsigned InColLsb  = 21;

  // output tdata layout
  localparam int unsigned OutColLsb  = 0;
  localparam int unsigned OutRowLsb  = 7;
  localparam int unsigned OutCharLsb = 12;
  localparam int unsigned OutAttrLsb = 20;
  localparam int unsigned OutScrLsb  = 28;

  localparam logic [7:0] NewlineCode = 8'd10;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_DEL   = 2'd1,
    REQ_STYLE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

endpackage

### rtl/text_console_cursor_buffer_top.sv
`timescale 1ns / 1ps

// Text console cell buffer with cursor.
// Input stream (s_axis_*): one request per transaction. tuser carries the
// request kind (put, delete, style, read); tdata carries character, colors
// and the read coordinates. Output stream (m_axis_*): one result per request
// with the cursor after the request, the read cell (zero for other kinds) and
// a scroll flag.
// The ROWS*COLS cells sit in one synchronous memory with one read and one
// write port. An ordinary request reads the cell, then writes the modified
// cell back together with the result (a read writes nothing back). A put that
// runs off the bottom row scrolls: one pass over the memory, one cell per cycle.
// After reset the block clears the memory; s_axis_tready stays low during that
// pass and the cursor sits at the origin.
// A result waits in the output register while m_axis_tready is low; the next
// request is still taken and held at its write-back until the register frees.
module text_console_cursor_buffer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], fg_color[11:8], bg_color[15:12], read_row[20:16],
  // read_col[27:21], zero[31:28]
  input  logic [tccb_pkg::InDataW-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [tccb_pkg::InUserW-1:0] s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cursor_col[6:0], cursor_row[11:7], cell_char[19:12], cell_attr[27:20],
  // scrolled[28], zero[31:29]
  output logic [tccb_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int N   = ROWS * COLS;
  localparam int TOP = (ROWS - 1) * COLS;
  localparam int AW  = $clog2(N);
  localparam int XW  = $clog2(COLS);
  localparam int YW  = $clog2(ROWS);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MOD    = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_SDRAIN = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [15:0] mem [N];
  logic [15:0] rdata_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd;

  logic [2:0]    state_q, state_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [AW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] wa_q, wa_d;
  logic          bot_q, bot_d;

  tccb_pkg::req_e req_q, req_d;
  logic [7:0]    ch_q, ch_d;
  logic [7:0]    attr_q, attr_d;
  logic          rd_ok_q, rd_ok_d;
  logic [AW-1:0] idx_q, idx_d;

  logic                          out_valid_q, out_valid_d;
  logic [tccb_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                          out_free;

  logic [7:0]                    in_ch;
  logic [3:0]                    in_fg, in_bg;
  logic [tccb_pkg::ReadRowW-1:0] in_row;
  logic [tccb_pkg::ReadColW-1:0] in_col;
  logic                          in_ok;
  logic [AW-1:0]                 cur_idx, del_idx, rd_idx;

  logic          del_moved;
  logic [XW-1:0] del_x;
  logic [YW-1:0] del_y;

  logic          m_we, m_scr, m_nl, m_wrap;
  logic [15:0]   m_wd;
  logic [XW-1:0] m_x;
  logic [YW-1:0] m_y;
  logic [7:0]    m_char, m_attr;

  function automatic logic [tccb_pkg::OutDataW-1:0] pack_out(
    input logic [XW-1:0] x,
    input logic [YW-1:0] y,
    input logic [7:0]    c,
    input logic [7:0]    a,
    input logic          s
  );
    logic [tccb_pkg::OutDataW-1:0] v;
    v = '0;
    v[tccb_pkg::OutColLsb +: tccb_pkg::CursorColW] = tccb_pkg::CursorColW'(x);
    v[tccb_pkg::OutRowLsb +: tccb_pkg::CursorRowW] = tccb_pkg::CursorRowW'(y);
    v[tccb_pkg::OutCharLsb +: 8] = c;
    v[tccb_pkg::OutAttrLsb +: 8] = a;
    v[tccb_pkg::OutScrLsb] = s;
    return v;
  endfunction

  assign in_ch  = s_axis_tdata[tccb_pkg::InCharLsb +: 8];
  assign in_fg  = s_axis_tdata[tccb_pkg::InFgLsb +: 4];
  assign in_bg  = s_axis_tdata[tccb_pkg::InBgLsb +: 4];
  assign in_row = s_axis_tdata[tccb_pkg::InRowLsb +: tccb_pkg::ReadRowW];
  assign in_col = s_axis_tdata[tccb_pkg::InColLsb +: tccb_pkg::ReadColW];
  assign in_ok  = (32'(in_row) < ROWS) && (32'(in_col) < COLS);

  assign cur_idx = AW'(32'(y_q) * COLS + 32'(x_q));
  assign del_idx = AW'(32'(del_y) * COLS + 32'(del_x));
  assign rd_idx  = in_ok ? AW'(32'(in_row) * COLS + 32'(in_col)) : '0;

  always_comb begin
    del_moved = 1'b1;
    del_x     = x_q;
    del_y     = y_q;
    if (x_q != '0) begin
      del_x = x_q - XW'(1);
    end else if (y_q == '0) begin
      del_moved = 1'b0;
    end else begin
      del_x = XW'(COLS - 1);
      del_y = y_q - YW'(1);
    end
  end

  always_comb begin
    m_we   = 1'b0;
    m_scr  = 1'b0;
    m_wd   = rdata_q;
    m_x    = x_q;
    m_y    = y_q;
    m_char = '0;
    m_attr = '0;
    m_nl   = (ch_q == tccb_pkg::NewlineCode);
    m_wrap = m_nl || (x_q == XW'(COLS - 1));
    unique case (req_q)
      tccb_pkg::REQ_PUT: begin
        m_we = !m_nl;
        m_wd = {rdata_q[15:8], ch_q};
        if (!m_wrap) begin
          m_x = x_q + XW'(1);
        end else if (y_q != YW'(ROWS - 1)) begin
          m_x = '0;
          m_y = y_q + YW'(1);
        end else begin
          m_x   = '0;
          m_scr = 1'b1;
        end
      end
      tccb_pkg::REQ_DEL: begin
        m_we = del_moved;
        m_wd = {rdata_q[15:8], 8'h00};
        m_x  = del_x;
        m_y  = del_y;
      end
      tccb_pkg::REQ_STYLE: begin
        m_we = 1'b1;
        m_wd = {attr_q, rdata_q[7:0]};
      end
      tccb_pkg::REQ_READ: begin
        if (rd_ok_q) begin
          m_char = rdata_q[7:0];
          m_attr = rdata_q[15:8];
        end
      end
      default: ;
    endcase
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    k_d         = k_q;
    pend_d      = 1'b0;
    wa_d        = wa_q;
    bot_d       = bot_q;
    req_d       = req_q;
    ch_d        = ch_q;
    attr_d      = attr_q;
    rd_ok_d     = rd_ok_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_wa      = wa_q;
    mem_wd      = bot_q ? {rdata_q[15:8], 8'h00} : rdata_q;
    mem_re      = 1'b0;
    mem_ra      = '0;

    if (pend_q) begin
      mem_we = 1'b1;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = k_q;
        mem_wd = '0;
        if (k_q == AW'(N - 1)) begin
          k_d     = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d   = tccb_pkg::req_e'(s_axis_tuser);
          ch_d    = in_ch;
          attr_d  = {in_bg, in_fg};
          rd_ok_d = in_ok;
          mem_re  = 1'b1;
          unique case (tccb_pkg::req_e'(s_axis_tuser))
            tccb_pkg::REQ_DEL:  mem_ra = del_idx;
            tccb_pkg::REQ_READ: mem_ra = rd_idx;
            default:            mem_ra = cur_idx;
          endcase
          idx_d   = mem_ra;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (m_scr || out_free) begin
          mem_we = m_we;
          mem_wa = idx_q;
          mem_wd = m_wd;
          x_d    = m_x;
          y_d    = m_y;
          if (m_scr) begin
            k_d     = '0;
            state_d = ST_SCROLL;
          end else begin
            out_valid_d = 1'b1;
            out_data_d  = pack_out(m_x, m_y, m_char, m_attr, 1'b0);
            state_d     = ST_IDLE;
          end
        end
      end
      ST_SCROLL: begin
        mem_re = 1'b1;
        mem_ra = (32'(k_q) < TOP) ? AW'(32'(k_q) + COLS) : k_q;
        pend_d = 1'b1;
        wa_d   = k_q;
        bot_d  = (32'(k_q) >= TOP);
        if (k_q == AW'(N - 1)) begin
          k_d     = '0;
          state_d = ST_SDRAIN;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      ST_SDRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = pack_out(x_q, y_q, 8'h00, 8'h00, 1'b1);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      x_q         <= '0;
      y_q         <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q       <= wa_d;
    bot_q      <= bot_d;
    req_q      <= req_d;
    ch_q       <= ch_d;
    attr_q     <= attr_d;
    rd_ok_q    <= rd_ok_d;
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
  end

endmodule

### rtl/tccb_checker.sv
`timescale 1ns / 1ps

module tccb_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tccb_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [tccb_pkg::CursorColW-1:0] out_col;
  logic [tccb_pkg::CursorRowW-1:0] out_row;
  logic                            out_scr;

  assign out_col = m_axis_tdata[tccb_pkg::OutColLsb +: tccb_pkg::CursorColW];
  assign out_row = m_axis_tdata[tccb_pkg::OutRowLsb +: tccb_pkg::CursorRowW];
  assign out_scr = m_axis_tdata[tccb_pkg::OutScrLsb];

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // block no request right out of reset: the clearing pass runs first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("request taken during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (COLS > 128) || (32'(out_col) < COLS)
                   && ((ROWS > 32) || (32'(out_row) < ROWS)))
    else $error("cursor out of screen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_scr |->
      (out_col == '0) && (out_row == tccb_pkg::CursorRowW'(ROWS - 1)))
    else $error("scroll left cursor off the bottom line start");

endmodule

bind text_console_cursor_buffer_top tccb_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tccb_checker (.*);

### verif/tb_text_console_cursor_buffer_top.sv
`timescale 1ns / 1ps

module tb_text_console_cursor_buffer_top;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int unsigned IdleLimit = 8000;
  localparam int unsigned RandomItems = 1550;

  typedef struct {
    tccb_pkg::req_e kind;
    logic [31:0]    data;
  } console_req_t;

  typedef struct packed {
    logic                            scrolled;
    logic [7:0]                      attr;
    logic [7:0]                      chr;
    logic [tccb_pkg::CursorRowW-1:0] row;
    logic [tccb_pkg::CursorColW-1:0] col;
  } console_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [tccb_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [tccb_pkg::InUserW-1:0]  s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [tccb_pkg::OutDataW-1:0] m_axis_tdata;

  console_req_t    request_q[$];
  console_result_t cursor_result_q[$];

  logic [15:0]                     screen_mem[ROWS*COLS];
  logic [tccb_pkg::CursorColW-1:0] cur_col;
  logic [tccb_pkg::CursorRowW-1:0] cur_row;

  int unsigned request_total = 0;
  int unsigned taken_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;

  text_console_cursor_buffer_top #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_req(tccb_pkg::req_e kind, logic [7:0] ch, logic [3:0] fg,
                                  logic [3:0] bg, logic [tccb_pkg::ReadRowW-1:0] rrow,
                                  logic [tccb_pkg::ReadColW-1:0] rcol);
    console_req_t r;
    r.kind = kind;
    r.data = '0;
    r.data[tccb_pkg::InCharLsb +: 8] = ch;
    r.data[tccb_pkg::InFgLsb +: 4] = fg;
    r.data[tccb_pkg::InBgLsb +: 4] = bg;
    r.data[tccb_pkg::InRowLsb +: tccb_pkg::ReadRowW] = rrow;
    r.data[tccb_pkg::InColLsb +: tccb_pkg::ReadColW] = rcol;
    request_q.push_back(r);
    request_total++;
  endfunction

  function automatic void add_rand(tccb_pkg::req_e kind, logic [7:0] ch);
    add_req(kind, ch, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
            5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endfunction

  function automatic void clear_screen();
    for (int i = 0; i < ROWS * COLS; i++) screen_mem[i] = 16'h0000;
    cur_col = '0;
    cur_row = '0;
  endfunction

  // Shift rows up; the new bottom row keeps its attributes, loses its characters.
  function automatic void scroll_screen();
    for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_mem[i] = screen_mem[i + COLS];
    for (int c = 0; c < COLS; c++) screen_mem[(ROWS - 1) * COLS + c][7:0] = 8'h00;
  endfunction

  function automatic logic advance_line();
    cur_col = '0;
    if (32'(cur_row) < ROWS - 1) begin
      cur_row++;
      return 1'b0;
    end
    scroll_screen();
    return 1'b1;
  endfunction

  function automatic console_result_t console_apply(tccb_pkg::req_e kind, logic [31:0] data);
    console_result_t res;
    logic [7:0] ch;
    int unsigned rrow;
    int unsigned rcol;
    int unsigned idx;
    res = '0;
    ch = data[tccb_pkg::InCharLsb +: 8];
    rrow = 32'(data[tccb_pkg::InRowLsb +: tccb_pkg::ReadRowW]);
    rcol = 32'(data[tccb_pkg::InColLsb +: tccb_pkg::ReadColW]);
    idx = 32'(cur_row) * COLS + 32'(cur_col);
    case (kind)
      tccb_pkg::REQ_PUT: begin
        if (ch == tccb_pkg::NewlineCode) begin
          res.scrolled = advance_line();
        end else begin
          screen_mem[idx][7:0] = ch;
          if (32'(cur_col) < COLS - 1) cur_col++;
          else res.scrolled = advance_line();
        end
      end
      tccb_pkg::REQ_DEL: begin
        if (cur_col != 0 || cur_row != 0) begin
          if (cur_col != 0) begin
            cur_col--;
          end else begin
            cur_col = tccb_pkg::CursorColW'(COLS - 1);
            cur_row--;
          end
          screen_mem[32'(cur_row) * COLS + 32'(cur_col)][7:0] = 8'h00;
        end
      end
      tccb_pkg::REQ_STYLE: begin
        screen_mem[idx][15:8] = {data[tccb_pkg::InBgLsb +: 4], data[tccb_pkg::InFgLsb +: 4]};
      end
      default: begin
        if (rrow < ROWS && rcol < COLS) begin
          res.chr = screen_mem[rrow * COLS + rcol][7:0];
          res.attr = screen_mem[rrow * COLS + rcol][15:8];
        end
      end
    endcase
    res.col = cur_col;
    res.row = cur_row;
    return res;
  endfunction

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      in_gap <= 0;
      in_calm <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (in_gap != 0 || request_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (in_gap != 0) in_gap <= in_gap - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= request_q[0].data;
        s_axis_tuser <= request_q[0].kind;
        void'(request_q.pop_front());
        if (in_calm != 0) begin
          in_calm <= in_calm - 1;
          in_gap <= 0;
        end else if ($urandom_range(0, 49) == 0) begin
          in_calm <= $urandom_range(30, 150);
          in_gap <= 0;
        end else begin
          in_gap <= pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_stall <= 0;
      out_calm <= 0;
    end else if (out_stall != 0) begin
      m_axis_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (out_calm != 0) begin
        out_calm <= out_calm - 1;
      end else if ($urandom_range(0, 99) == 0) begin
        out_calm <= $urandom_range(30, 200);
      end else begin
        out_stall <= pick_gap();
      end
    end
  end

  // Predict on every accepted request, then check any accepted result.
  always @(posedge clk_i) begin
    console_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        cursor_result_q.push_back(console_apply(tccb_pkg::req_e'(s_axis_tuser), s_axis_tdata));
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (cursor_result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result: tdata %08h", m_axis_tdata);
        end else begin
          want = cursor_result_q.pop_front();
          if (m_axis_tdata[tccb_pkg::OutColLsb +: tccb_pkg::CursorColW] != want.col)
            note_mismatch("cursor_col", 32'(want.col),
                          32'(m_axis_tdata[tccb_pkg::OutColLsb +: tccb_pkg::CursorColW]));
          if (m_axis_tdata[tccb_pkg::OutRowLsb +: tccb_pkg::CursorRowW] != want.row)
            note_mismatch("cursor_row", 32'(want.row),
                          32'(m_axis_tdata[tccb_pkg::OutRowLsb +: tccb_pkg::CursorRowW]));
          if (m_axis_tdata[tccb_pkg::OutCharLsb +: 8] != want.chr)
            note_mismatch("cell_char", 32'(want.chr),
                          32'(m_axis_tdata[tccb_pkg::OutCharLsb +: 8]));
          if (m_axis_tdata[tccb_pkg::OutAttrLsb +: 8] != want.attr)
            note_mismatch("cell_attr", 32'(want.attr),
                          32'(m_axis_tdata[tccb_pkg::OutAttrLsb +: 8]));
          if (m_axis_tdata[tccb_pkg::OutScrLsb] != want.scrolled)
            note_mismatch("scrolled", 32'(want.scrolled),
                          32'(m_axis_tdata[tccb_pkg::OutScrLsb]));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    clear_screen();

    add_req(tccb_pkg::REQ_DEL, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_STYLE, 8'h00, 4'hF, 4'hF, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_PUT, 8'hFF, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_PUT, 8'h00, 4'hF, 4'hF, 5'd31, 7'd127);
    add_req(tccb_pkg::REQ_PUT, tccb_pkg::NewlineCode, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_DEL, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_STYLE, 8'h00, 4'h5, 4'hA, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_PUT, 8'h41, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_DEL, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_PUT, 8'h0B, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd79);
    add_req(tccb_pkg::REQ_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0);
    add_req(tccb_pkg::REQ_READ, 8'h00, 4'h0, 4'h0, 5'd24, 7'd79);
    add_req(tccb_pkg::REQ_READ, 8'h00, 4'h0, 4'h0, 5'd25, 7'd0);
    add_req(tccb_pkg::REQ_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd80);
    add_req(tccb_pkg::REQ_READ, 8'hFF, 4'hF, 4'hF, 5'd31, 7'd127);
    add_req(tccb_pkg::REQ_STYLE, 8'h00, 4'h0, 4'hF, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_PUT, 8'h09, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_PUT, 8'h0A, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_STYLE, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_DEL, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0);
    add_req(tccb_pkg::REQ_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd1);

    while (request_total < RandomItems + 23) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        n = $urandom_range(1, 90);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0)
            add_rand(tccb_pkg::REQ_PUT, tccb_pkg::NewlineCode);
          else
            add_rand(tccb_pkg::REQ_PUT, 8'($urandom_range(0, 255)));
        end
      end else if (pick < 45) begin
        n = $urandom_range(1, 30);
        repeat (n) add_req(tccb_pkg::REQ_PUT, tccb_pkg::NewlineCode, 4'h0, 4'h0, 5'd0, 7'd0);
      end else if (pick < 58) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
        repeat (n) add_rand(tccb_pkg::REQ_DEL, 8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          add_rand(tccb_pkg::REQ_STYLE, 8'($urandom_range(0, 255)));
          add_rand(tccb_pkg::REQ_PUT, 8'($urandom_range(0, 255)));
        end
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          add_req(tccb_pkg::REQ_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)),
                  5'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, 24)),
                  7'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 79)));
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (taken_cnt < request_total) @(posedge clk_i);
    while (cursor_result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && cursor_result_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
